[rtl/core/mwps_pkg.sv]
// ----------------------------------------------------------------------------
// mwps_pkg
// Shared types and constants of the masked word pattern search unit.
// ----------------------------------------------------------------------------
package mwps_pkg;

    localparam int WORD_W    = 64;
    localparam int ADDR_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int PWORDS_W  = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_FIRST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_SECOND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORDS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT      = 3'd5;

    localparam logic [WORD_W-1:0]   ALL_ONES  = {WORD_W{1'b1}};
    localparam logic [LIMIT_W-1:0]  COUNT_MAX = {LIMIT_W{1'b1}};

    typedef struct packed {
        logic [WORD_W-1:0] pattern_first;
        logic [WORD_W-1:0] pattern_second;
        logic [WORD_W-1:0] mask_first;
        logic [WORD_W-1:0] mask_second;
        logic              two_word;
    } t_cfg;

    typedef struct packed {
        logic match;
        logic use_prev;
    } t_match;

endpackage

[rtl/core/mwps_match.sv]
// ----------------------------------------------------------------------------
// mwps_match
// Masked compare of the current word, or of the previous and current word
// for a two-word pattern.
// ----------------------------------------------------------------------------
module mwps_match (
    input  mwps_pkg::t_cfg                  i_cfg,
    input  logic [mwps_pkg::WORD_W-1:0]     i_word,
    input  logic [mwps_pkg::WORD_W-1:0]     i_prev_word,
    input  logic                            i_prev_valid,
    output mwps_pkg::t_match                o_match
);
    import mwps_pkg::*;

    logic cur_first;
    logic prev_first;
    logic cur_second;

    assign cur_first  = (i_word & i_cfg.mask_first) ==
                        (i_cfg.pattern_first & i_cfg.mask_first);
    assign prev_first = (i_prev_word & i_cfg.mask_first) ==
                        (i_cfg.pattern_first & i_cfg.mask_first);
    assign cur_second = (i_word & i_cfg.mask_second) ==
                        (i_cfg.pattern_second & i_cfg.mask_second);

    always_comb begin
        o_match.use_prev = i_cfg.two_word;
        if (i_cfg.two_word) begin
            o_match.match = i_prev_valid && prev_first && cur_second;
        end else begin
            o_match.match = cur_first;
        end
    end

endmodule

[rtl/core/masked_word_pattern_search_unit.sv]
// ----------------------------------------------------------------------------
// masked_word_pattern_search_unit
// Reports the first masked pattern match of each block of memory words, up to an optional hit limit.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata: mem_word[63:0], word_addr[95:64]; tuser: block_first
//  m_axis    out  tdata: hit_addr[31:0], hit_value[95:32]; tuser: limit_reached
//  cfg       in   write enable, register index, 64-bit data
//
//  One beat per cycle while input is not held off; a hit is shown in the cycle after its input beat.
//  The rate is set by the masked compare feeding the result register.
//  Input is held off only while a result waits and m_axis is stalled.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module masked_word_pattern_search_unit #(
    parameter int MAX_PATTERN_WORDS = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [95:0]                     i_s_axis_tdata,  // mem_word, word_addr
    input  logic [0:0]                      i_s_axis_tuser,  // block_first
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [95:0]                     o_m_axis_tdata,  // hit_addr, hit_value
    output logic [0:0]                      o_m_axis_tuser,  // limit_reached
    input  logic                            i_cfg_we,
    input  logic [mwps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mwps_pkg::WORD_W-1:0]     i_cfg_data
);
    import mwps_pkg::*;

    logic [WORD_W-1:0]   r_pattern_first;
    logic [WORD_W-1:0]   r_pattern_second;
    logic [WORD_W-1:0]   r_mask_first;
    logic [WORD_W-1:0]   r_mask_second;
    logic [PWORDS_W-1:0] r_pattern_words;
    logic [LIMIT_W-1:0]  r_hit_limit;

    logic [WORD_W-1:0]   r_prev_word;
    logic [ADDR_W-1:0]   r_prev_addr;
    logic                r_prev_valid;
    logic                r_block_found;
    logic [LIMIT_W-1:0]  r_hit_count;

    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [WORD_W-1:0]   r_out_value;
    logic                r_out_limit;

    logic [WORD_W-1:0]   in_word;
    logic [ADDR_W-1:0]   in_addr;
    logic                in_first;
    logic                s_accept;
    logic                prev_valid_eff;
    logic                found_eff;
    logic                limit_ok;
    logic                report;
    logic [LIMIT_W-1:0]  n_hit_count;
    t_cfg                cfg;
    t_match              mres;

    assign in_word  = i_s_axis_tdata[WORD_W-1:0];
    assign in_addr  = i_s_axis_tdata[WORD_W+ADDR_W-1:WORD_W];
    assign in_first = i_s_axis_tuser[0];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign cfg.pattern_first  = r_pattern_first;
    assign cfg.pattern_second = r_pattern_second;
    assign cfg.mask_first     = r_mask_first;
    assign cfg.mask_second    = r_mask_second;
    assign cfg.two_word       = (MAX_PATTERN_WORDS >= 2) && r_pattern_words[1];

    assign prev_valid_eff = r_prev_valid && !in_first;
    assign found_eff      = r_block_found && !in_first;

    mwps_match u_match (
        .i_cfg        (cfg),
        .i_word       (in_word),
        .i_prev_word  (r_prev_word),
        .i_prev_valid (prev_valid_eff),
        .o_match      (mres)
    );

    assign limit_ok    = (r_hit_limit == '0) || (r_hit_count < r_hit_limit);
    assign report      = mres.match && !found_eff && limit_ok;
    assign n_hit_count = (r_hit_count != COUNT_MAX) ? r_hit_count + 1'b1 : r_hit_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_first  <= '0;
            r_pattern_second <= '0;
            r_mask_first     <= ALL_ONES;
            r_mask_second    <= ALL_ONES;
            r_pattern_words  <= PWORDS_W'(1);
            r_hit_limit      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_FIRST:  r_pattern_first  <= i_cfg_data;
                CFG_PATTERN_SECOND: r_pattern_second <= i_cfg_data;
                CFG_MASK_FIRST:     r_mask_first     <= i_cfg_data;
                CFG_MASK_SECOND:    r_mask_second    <= i_cfg_data;
                CFG_PATTERN_WORDS:  r_pattern_words  <= i_cfg_data[PWORDS_W-1:0];
                CFG_HIT_LIMIT:      r_hit_limit      <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid  <= 1'b0;
            r_block_found <= 1'b0;
            r_hit_count   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s_accept) begin
                r_prev_valid  <= 1'b1;
                r_block_found <= found_eff || report;
                if (report) begin
                    r_hit_count <= n_hit_count;
                end
            end
            if (s_accept && report) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_prev_word <= in_word;
            r_prev_addr <= in_addr;
        end
        if (s_accept && report) begin
            r_out_addr  <= mres.use_prev ? r_prev_addr : in_addr;
            r_out_value <= mres.use_prev ? r_prev_word : in_word;
            r_out_limit <= (r_hit_limit != '0) && (n_hit_count == r_hit_limit);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_value, r_out_addr};
    assign o_m_axis_tuser  = r_out_limit;

`ifndef SYNTHESIS
    a_report_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && report |=> o_m_axis_tvalid)
        else $error("hit not presented on m_axis");

    a_one_per_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_block_found && !in_first |-> !report)
        else $error("second hit reported in one block");

    a_ready_only_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input held off without a stalled result");
`endif

endmodule

[bench/mwps_search_checker.sv]
// ----------------------------------------------------------------------------
// mwps_search_checker
// Watches the word stream, the hit stream and the register writes of the
// masked word pattern search unit. It keeps its own copy of the search state,
// predicts the hit of each input beat and compares every hit beat with the
// oldest hit still due.
// ----------------------------------------------------------------------------
module mwps_search_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [95:0]                     i_s_tdata,   // mem_word, word_addr
    input  logic [0:0]                      i_s_tuser,   // block_first
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [95:0]                     i_m_tdata,   // hit_addr, hit_value
    input  logic [0:0]                      i_m_tuser,   // limit_reached
    input  logic                            i_cfg_we,
    input  logic [mwps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mwps_pkg::WORD_W-1:0]     i_cfg_data,
    output int                              o_mismatches,
    output int                              o_hits_due,
    output logic [mwps_pkg::LIMIT_W-1:0]    o_hit_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mwps_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] value;
        logic              limit;
    } t_hit;

    t_hit hits_due[$];
    t_hit due_hit;
    t_hit seen_hit;
    t_hit new_hit;

    logic [WORD_W-1:0]   pat_first;
    logic [WORD_W-1:0]   pat_second;
    logic [WORD_W-1:0]   care_first;
    logic [WORD_W-1:0]   care_second;
    logic [PWORDS_W-1:0] pat_words;
    logic [LIMIT_W-1:0]  limit_max;

    logic [WORD_W-1:0]   last_word;
    logic [ADDR_W-1:0]   last_addr;
    logic                last_in_block;
    logic                block_done;
    logic [LIMIT_W-1:0]  hits_made;

    task automatic flag_mismatch(input string what, input logic [96:0] got,
                                 input logic [96:0] want);
        if (o_mismatches < 30)
            $display("mismatch on %s: got %h, expected %h", what, got, want);
        o_mismatches++;
    endtask

    // Length 0 acts as one word, 3 as two words.
    function automatic bit search_word(input logic [WORD_W-1:0] word,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic first, output t_hit hit);
        logic found;
        logic two;
        if (first) begin
            last_in_block = 1'b0;
            block_done    = 1'b0;
        end
        two = (pat_words >= 2'd2);
        if (!two) begin
            found     = (word & care_first) == (pat_first & care_first);
            hit.addr  = addr;
            hit.value = word;
        end else begin
            found     = last_in_block &&
                        ((last_word & care_first) == (pat_first & care_first)) &&
                        ((word & care_second) == (pat_second & care_second));
            hit.addr  = last_addr;
            hit.value = last_word;
        end
        hit.limit   = 1'b0;
        search_word = 1'b0;
        if (found && !block_done && (limit_max == '0 || hits_made < limit_max)) begin
            block_done = 1'b1;
            if (hits_made != COUNT_MAX) hits_made++;
            hit.limit   = (limit_max != '0) && (hits_made == limit_max);
            search_word = 1'b1;
        end
        last_word     = word;
        last_addr     = addr;
        last_in_block = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_first     = '0;
            pat_second    = '0;
            care_first    = ALL_ONES;
            care_second   = ALL_ONES;
            pat_words     = 2'd1;
            limit_max     = '0;
            last_word     = '0;
            last_addr     = '0;
            last_in_block = 1'b0;
            block_done    = 1'b0;
            hits_made     = '0;
            hits_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen_hit.addr  = i_m_tdata[31:0];
                seen_hit.value = i_m_tdata[95:32];
                seen_hit.limit = i_m_tuser[0];
                if (hits_due.size() == 0) begin
                    flag_mismatch("unexpected hit", {i_m_tuser, i_m_tdata}, '0);
                end else begin
                    due_hit = hits_due.pop_front();
                    if (seen_hit.addr != due_hit.addr)
                        flag_mismatch("hit_addr", 97'(seen_hit.addr), 97'(due_hit.addr));
                    if (seen_hit.value != due_hit.value)
                        flag_mismatch("hit_value", 97'(seen_hit.value),
                                      97'(due_hit.value));
                    if (seen_hit.limit != due_hit.limit)
                        flag_mismatch("limit_reached", 97'(seen_hit.limit),
                                      97'(due_hit.limit));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (search_word(i_s_tdata[63:0], i_s_tdata[95:64], i_s_tuser[0], new_hit))
                    hits_due.push_back(new_hit);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PATTERN_FIRST:  pat_first   = i_cfg_data;
                    CFG_PATTERN_SECOND: pat_second  = i_cfg_data;
                    CFG_MASK_FIRST:     care_first  = i_cfg_data;
                    CFG_MASK_SECOND:    care_second = i_cfg_data;
                    CFG_PATTERN_WORDS:  pat_words   = i_cfg_data[PWORDS_W-1:0];
                    CFG_HIT_LIMIT:      limit_max   = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_hits_due  <= hits_due.size();
        o_hit_count <= hits_made;
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the masked word pattern search unit. Drives directed word
// streams over the block-boundary, length and limit cases, then random block
// streams built partly from masked pattern fits under several register
// settings and idle/stall mixes. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BEATS   = 130;
    localparam int PHASES        = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [95:0]          i_s_axis_tdata = '0;   // mem_word, word_addr
    logic [0:0]           i_s_axis_tuser = '0;   // block_first
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [95:0]          o_m_axis_tdata;        // hit_addr, hit_value
    logic [0:0]           o_m_axis_tuser;        // limit_reached
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    int                   mismatches;
    int                   hits_due;
    logic [LIMIT_W-1:0]   hit_total;

    int send_pct  = 0;
    int stall_pct = 0;
    int idle_cycles = 0;
    int n_beats = 0;
    int n_hits = 0;
    int n_settings = 0;

    logic [WORD_W-1:0]   cur_pf = '0;
    logic [WORD_W-1:0]   cur_ps = '0;
    logic [WORD_W-1:0]   cur_mf = ALL_ONES;
    logic [WORD_W-1:0]   cur_ms = ALL_ONES;
    logic [PWORDS_W-1:0] cur_pw = 2'd1;
    logic [ADDR_W-1:0]   next_addr = '0;

    masked_word_pattern_search_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    mwps_search_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_hits_due   (hits_due),
        .o_hit_count  (hit_total)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) n_hits <= n_hits + 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_s_axis_tvalid && o_s_axis_tready) ||
                     (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Word that matches pat under care, random in the don't-care bits.
    function automatic logic [WORD_W-1:0] fit(input logic [WORD_W-1:0] pat,
                                              input logic [WORD_W-1:0] care);
        return (pat & care) | (rand64() & ~care);
    endfunction

    task automatic send_beat(input logic [WORD_W-1:0] word,
                             input logic [ADDR_W-1:0] addr, input logic first);
        if ($urandom_range(99) < send_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {addr, word};
        i_s_axis_tuser  <= first;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_beats++;
    endtask

    // Block goes quiet: no beat in flight, no hit due, pipeline drained.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (hits_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Upper data bits of the narrow registers are random to show they drop.
    task automatic apply_settings(input logic [WORD_W-1:0] pf, input logic [WORD_W-1:0] ps,
                                  input logic [WORD_W-1:0] mf, input logic [WORD_W-1:0] ms,
                                  input logic [PWORDS_W-1:0] pw,
                                  input logic [LIMIT_W-1:0] hl, input bit spare);
        logic [WORD_W-1:0] d;
        settle();
        cfg_write(CFG_PATTERN_FIRST, pf);
        cfg_write(CFG_PATTERN_SECOND, ps);
        cfg_write(CFG_MASK_FIRST, mf);
        cfg_write(CFG_MASK_SECOND, ms);
        d = rand64();
        d[PWORDS_W-1:0] = pw;
        cfg_write(CFG_PATTERN_WORDS, d);
        d = rand64();
        d[LIMIT_W-1:0] = hl;
        cfg_write(CFG_HIT_LIMIT, d);
        if (spare) begin
            cfg_write(CFG_SPARE_LO, rand64());
            cfg_write(CFG_SPARE_HI, rand64());
        end
        i_cfg_we <= 1'b0;
        cur_pf = pf;
        cur_ps = ps;
        cur_mf = mf;
        cur_ms = ms;
        cur_pw = pw;
        n_settings++;
    endtask

    // Random blocks; in two-word mode a first-pattern word is mostly followed by a second-pattern fit.
    task automatic feed_blocks(input int n);
        logic [WORD_W-1:0] w;
        logic first;
        bit armed;
        bit two;
        int r;
        two   = cur_pw[1];
        armed = 1'b0;
        for (int k = 0; k < n; k++) begin
            first = ($urandom_range(5) == 0);
            if (first && $urandom_range(1)) next_addr = $urandom & ~32'h7;
            if ($urandom_range(32) == 0) next_addr = $urandom;
            r = $urandom_range(99);
            if (two && armed && r < 70)
                w = fit(cur_ps, cur_ms);
            else if (r < 30)
                w = fit(cur_pf, cur_mf);
            else if (r < 40)
                w = fit(cur_pf, cur_mf) ^ (64'd1 << $urandom_range(63));
            else if (r < 48)
                w = $urandom_range(1) ? ALL_ONES : '0;
            else
                w = rand64();
            armed = ((w & cur_mf) == (cur_pf & cur_mf));
            send_beat(w, next_addr, first);
            next_addr += 8;
        end
    endtask

    initial begin
        logic [WORD_W-1:0] pa;
        logic [WORD_W-1:0] pb;
        logic [WORD_W-1:0] pf;
        logic [WORD_W-1:0] ps;
        logic [WORD_W-1:0] mf;
        logic [WORD_W-1:0] ms;
        logic [PWORDS_W-1:0] pw;
        logic [LIMIT_W-1:0] hl;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one word, pattern zero, all bits cared for.
        send_beat('0, 32'h0000_0000, 1'b0);      // no block mark yet
        send_beat('0, 32'h0000_0008, 1'b0);      // block already reported
        send_beat(ALL_ONES, 32'hFFFF_FFF8, 1'b1);
        send_beat('0, 32'hFFFF_FFFF, 1'b0);      // unaligned address

        pa = rand64();
        pb = rand64();
        apply_settings(pa, pb, ALL_ONES, ALL_ONES, 2'd2, '0, 1'b0);
        send_beat(pb, 32'h0000_1000, 1'b1);      // no previous word
        send_beat(pa, 32'h0000_1008, 1'b0);
        send_beat(pb, 32'h0000_2000, 1'b1);      // pair straddles blocks
        send_beat(pa, 32'h0000_2008, 1'b0);
        send_beat(pb, 32'h0000_2010, 1'b0);
        send_beat(pa, 32'h0000_3000, 1'b1);
        send_beat(pb, 32'h0000_3008, 1'b0);

        // Length zero acts as one; limit hit on the next report.
        settle();
        apply_settings(ALL_ONES, rand64(), 64'h00FF_00FF_00FF_00FF, '0, 2'd0,
                       hit_total + 16'd1, 1'b1);
        send_beat(ALL_ONES, 32'h0000_4000, 1'b1);
        send_beat(fit(ALL_ONES, 64'h00FF_00FF_00FF_00FF), 32'h0000_5000, 1'b1);

        // Length three acts as two; empty masks match any pair.
        apply_settings('0, ALL_ONES, '0, '0, 2'd3, '0, 1'b0);
        send_beat(rand64(), 32'h0000_6000, 1'b1);
        send_beat(rand64(), 32'h0000_6008, 1'b0);
        send_beat(rand64(), 32'h0000_7000, 1'b1);
        send_beat(rand64(), 32'h0000_7008, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: pw = 2'd1;
                1: pw = 2'd2;
                2: pw = 2'd0;
                default: pw = 2'd3;
            endcase
            pf = (p == 0) ? ALL_ONES : (p == 1) ? '0 : rand64();
            ps = (p == 3) ? ALL_ONES : rand64();
            mf = (p == 0) ? ALL_ONES : (p == 2) ? '0 :
                 (p % 2) ? (rand64() & rand64()) : rand64();
            ms = (p == 5) ? '0 : (p == 3) ? ALL_ONES : (rand64() & rand64());
            settle();
            hl = (p < 6) ? '0 : (p == 6) ? hit_total + 16'd5 : 16'hFFFF;
            apply_settings(pf, ps, mf, ms, pw, hl, 1'b0);
            case (p % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 87; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 87; end
                default: begin send_pct = 8; stall_pct = 8; end
            endcase
            feed_blocks(PHASE_BEATS);
        end

        settle();
        $display("run covered %0d word beats under %0d register settings", n_beats, n_settings);
        $display("%0d hits returned, %0d counted by the search", n_hits, hit_total);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
